[rtl/tcst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tcst_pkg;
  localparam int MaxRegions = 64;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);

  typedef enum logic [2:0] {
    PH_RESTART = 3'd0,
    PH_FIRST   = 3'd1,
    PH_DOUBLE  = 3'd2,
    PH_REFINE  = 3'd3,
    PH_FINAL   = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_READ, ST_UPDATE, ST_RESP
  } state_t;

  localparam logic [1:0] CfgStart = 2'd0;
  localparam logic [1:0] CfgCores = 2'd1;
  localparam logic [1:0] CfgMode  = 2'd2;

  typedef struct packed {
    phase_t       phase;
    logic [8:0]   trial;
    logic [8:0]   best;
    logic [8:0]   prev;
    logic [8:0]   step;
    logic [47:0]  best_metric;
    logic         seq;
    logic         fallback;
  } slot_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

  function automatic logic [8:0] sat9(input logic [9:0] v);
    return v[9] ? 9'h1FF : v[8:0];
  endfunction
endpackage
`default_nettype wire

[rtl/tcst_key_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcst_key_scan
  import tcst_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic [63:0]     key,
  input  wire logic [CntW-1:0] count,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_idx,
  output scan_stat_t           stat,
  output logic [IdxW-1:0]      hit_idx
);
  logic [63:0]     keys_mem [MaxRegions];
  logic [63:0]     rd_r;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic [CntW-1:0] rd_ptr_r;
  logic            rd_vld_r, rd_vld_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            hit_r, hit_nxt;
  logic [IdxW-1:0] hit_idx_r, hit_idx_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_mem[wr_idx] <= key;
    end
    rd_r     <= keys_mem[ptr_r[IdxW-1:0]];
    rd_ptr_r <= ptr_r;
  end

  // one read per cycle; compare the previous cycle's registered read
  always_comb begin
    ptr_nxt = ptr_r;
    rd_vld_nxt = 1'b0;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    if (go) begin
      ptr_nxt = '0;
      busy_nxt = 1'b1;
      hit_nxt = 1'b0;
    end else if (busy_r) begin
      if (rd_vld_r && rd_r == key) begin
        hit_nxt = 1'b1;
        hit_idx_nxt = rd_ptr_r[IdxW-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (ptr_r >= count) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rd_vld_nxt = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      rd_vld_r <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      rd_vld_r <= rd_vld_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      hit_r <= hit_nxt;
    end
    hit_idx_r <= hit_idx_nxt;
  end

  assign stat.done = done_r;
  assign stat.hit  = hit_r;
  assign hit_idx   = hit_idx_r;
endmodule
`default_nettype wire

[rtl/tcst_search_step.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcst_search_step
  import tcst_pkg::*;
(
  input  wire slot_t        cur,
  input  wire logic [8:0]   start_threads,
  input  wire logic [8:0]   core_count,
  input  wire logic [2:0]   metric_mode,
  input  wire logic [31:0]  elapsed,
  input  wire logic [47:0]  metric,
  output slot_t             nxt
);
  logic               timed;
  logic signed [47:0] res;
  logic               lt, bad;
  logic [8:0]         hstep, rstep;
  logic [8:0]         ref_up, ref_dn;

  always_comb begin
    timed = cur.fallback || metric_mode == 3'd0 || metric_mode > 3'd4;
    res   = timed ? $signed({16'd0, elapsed}) : $signed(metric);
    bad   = !timed && (res <= 48'sd0);
    lt    = res < $signed(cur.best_metric);
    hstep = cur.prev >> 1;
    ref_up = sat9({1'b0, cur.trial} + {1'b0, hstep});
    ref_dn = (cur.trial > hstep) ? cur.trial - hstep : 9'd0;
    rstep = cur.step >> 1;
    nxt = cur;
    if (cur.phase != PH_DONE) begin
      if (bad) begin
        nxt.fallback = 1'b1;
        nxt.phase = PH_FIRST;
        nxt.trial = start_threads;
        nxt.prev  = start_threads;
      end else begin
        unique case (cur.phase)
          PH_RESTART: begin
            nxt.phase = PH_FIRST;
            nxt.trial = start_threads;
            nxt.prev  = start_threads;
          end
          PH_FIRST: begin
            nxt.best_metric = res;
            nxt.best = cur.trial;
            nxt.trial = sat9({cur.trial, 1'b0});
            nxt.phase = PH_DOUBLE;
          end
          PH_DOUBLE: begin
            if (lt) begin
              nxt.best_metric = res;
              nxt.best = cur.trial;
              if (!cur.seq) begin
                if ({cur.trial, 1'b0} <= {1'b0, core_count}) begin
                  nxt.prev = cur.trial;
                  nxt.trial = sat9({cur.trial, 1'b0});
                end else begin
                  nxt.step = hstep;
                  nxt.trial = ref_dn;
                  nxt.phase = (hstep == 9'd1) ? PH_FINAL : PH_REFINE;
                end
              end else begin
                nxt.phase = PH_DONE;
              end
            end else if ({1'b0, cur.trial} == {start_threads, 1'b0} && !cur.seq) begin
              nxt.prev = cur.trial;
              nxt.trial = 9'd1;
              nxt.seq = 1'b1;
            end else begin
              nxt.step = hstep;
              nxt.trial = (cur.best == (core_count >> 1)) ? ref_dn : ref_up;
              nxt.phase = (hstep == 9'd1) ? PH_FINAL : PH_REFINE;
            end
          end
          PH_REFINE: begin
            if (!($signed(cur.best_metric) < res)) begin
              nxt.best = cur.trial;
              nxt.best_metric = res;
            end
            nxt.step = rstep;
            nxt.trial = sat9({1'b0, cur.trial} + {1'b0, rstep});
            nxt.phase = (rstep == 9'd1) ? PH_FINAL : PH_REFINE;
          end
          PH_FINAL: begin
            nxt.phase = PH_DONE;
            if (lt) nxt.best = cur.trial;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[rtl/thread_count_search_tuner_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Response: a start raises out_valid after a sequential key scan (one table read
// per cycle) and the READ, UPDATE and RESP states; an end skips the scan and
// raises it after the READ, UPDATE and RESP states.
// Throughput: one transaction at a time; busy falls as out_valid rises.
// The result strobes for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the table and restores registers.
module thread_count_search_tuner_unit
  import tcst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [63:0] in_region_key,
  input  wire logic [31:0] in_elapsed_time,
  input  wire logic [47:0] in_metric_value,
  output logic             out_valid,
  output logic [8:0]       out_thread_count,
  output logic [5:0]       out_region_index,
  output logic             out_is_new_region,
  output logic             out_search_done,
  output logic             out_table_full,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  state_t state_r, state_nxt;
  logic [8:0]  start_r, cores_r;
  logic [2:0]  mode_r;
  logic        op_r;
  logic [63:0] key_r;
  logic [31:0] el_r;
  logic [47:0] mv_r;
  logic [CntW-1:0] cnt_r;
  logic [IdxW-1:0] cur_r, idx_r;
  logic        cur_vld_r;
  logic [MaxRegions-1:0] vld_r;
  slot_t       slot_mem [MaxRegions];
  slot_t       rd_slot_r, slot_eff, slot_new, res_slot;
  logic        accept, scan_go, key_wr, slot_wr, do_init;
  scan_stat_t  sstat;
  logic [IdxW-1:0] hit_idx;
  slot_t       init_slot;
  logic        new_r, full_r;

  assign accept = start && !busy;
  assign busy = state_r != ST_IDLE;

  always_comb begin
    init_slot = '0;
    init_slot.phase = PH_RESTART;
    init_slot.trial = start_r;
    init_slot.prev  = start_r;
  end

  tcst_key_scan u_scan (
    .clk, .rst_n, .go(scan_go), .key(key_r), .count(cnt_r),
    .wr_en(key_wr), .wr_idx(cnt_r[IdxW-1:0]), .stat(sstat), .hit_idx
  );

  assign slot_eff = vld_r[idx_r] ? rd_slot_r : init_slot;

  tcst_search_step u_step (
    .cur(slot_eff), .start_threads(start_r), .core_count(cores_r),
    .metric_mode(mode_r), .elapsed(el_r), .metric(mv_r), .nxt(slot_new)
  );

  // slot state after this transaction: updated on end, as read on start
  assign res_slot = op_r ? slot_new : slot_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = in_operation ? ST_READ : ST_SCAN;
      ST_SCAN:   if (sstat.done) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_RESP;
      ST_RESP:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_go = accept && !in_operation;
    key_wr  = state_r == ST_SCAN && sstat.done && !sstat.hit &&
              cnt_r < CntW'(MaxRegions);
    do_init = key_wr;
    slot_wr = state_r == ST_UPDATE && cur_vld_r && (op_r || new_r);
  end

  always_ff @(posedge clk) begin
    if (slot_wr) slot_mem[idx_r] <= res_slot;
    rd_slot_r <= slot_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 9'd1;
      cores_r <= 9'd8;
      mode_r <= 3'd0;
      cnt_r <= '0;
      cur_r <= '0;
      cur_vld_r <= 1'b0;
      vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= state_r == ST_RESP;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgStart: start_r <= cfg_data;
          CfgCores: cores_r <= cfg_data;
          CfgMode:  mode_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (state_r == ST_SCAN && sstat.done) begin
        if (sstat.hit) begin
          cur_r <= hit_idx;
          cur_vld_r <= 1'b1;
        end else if (key_wr) begin
          cur_r <= cnt_r[IdxW-1:0];
          cur_vld_r <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          cur_vld_r <= 1'b0;
        end
      end
      if (do_init) vld_r[cnt_r[IdxW-1:0]] <= 1'b0;
      if (slot_wr) vld_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      key_r <= in_region_key;
      el_r <= in_elapsed_time;
      mv_r <= in_metric_value;
      idx_r <= cur_r;
    end
    if (state_r == ST_SCAN && sstat.done) begin
      idx_r <= sstat.hit ? hit_idx : cnt_r[IdxW-1:0];
      new_r <= key_wr;
      full_r <= !sstat.hit && !key_wr;
    end
    if (accept && in_operation) begin
      new_r <= 1'b0;
      full_r <= 1'b0;
    end
  end

  // capture the result while the slot is at hand; hold it through the strobe
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_is_new_region <= new_r;
      out_table_full <= full_r;
      if (full_r || (op_r && !cur_vld_r)) begin
        out_thread_count <= full_r ? start_r : 9'd0;
        out_region_index <= '0;
        out_search_done <= 1'b0;
      end else begin
        out_region_index <= 6'(idx_r);
        out_search_done <= res_slot.phase == PH_DONE;
        out_thread_count <= res_slot.phase == PH_DONE ? res_slot.best : res_slot.trial;
      end
    end
  end
endmodule
`default_nettype wire

[bench/tcst_result_checker.sv]
`timescale 1ns / 1ps
module tcst_result_checker
  import tcst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_operation,
  input  wire logic [63:0] in_region_key,
  input  wire logic [31:0] in_elapsed_time,
  input  wire logic [47:0] in_metric_value,
  input  wire logic        out_valid,
  input  wire logic [8:0]  out_thread_count,
  input  wire logic [5:0]  out_region_index,
  input  wire logic        out_is_new_region,
  input  wire logic        out_search_done,
  input  wire logic        out_table_full,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output int               errors,
  output int               pending
);
  typedef struct {
    logic [8:0] threads;
    logic [5:0] slot;
    logic       fresh;
    logic       done;
    logic       full;
  } tuner_answer_t;

  tuner_answer_t answer_q[$];

  int unsigned reg_start, reg_cores, reg_mode;
  logic [63:0] key_tab[MaxRegions];
  int unsigned key_count, cur_slot;
  bit          cur_ok;
  phase_t      ph[MaxRegions];
  int unsigned trial[MaxRegions], best[MaxRegions], prev[MaxRegions], step[MaxRegions];
  longint      best_m[MaxRegions];
  bit          seq_done[MaxRegions], fallback[MaxRegions];

  function automatic int unsigned clip9(int unsigned v);
    return v > 511 ? 511 : v;
  endfunction

  function automatic void clear_slot(int unsigned r);
    ph[r] = PH_RESTART;
    trial[r] = reg_start;
    prev[r] = reg_start;
    best[r] = 0;
    step[r] = 0;
    best_m[r] = 0;
    seq_done[r] = 0;
    fallback[r] = 0;
  endfunction

  function automatic void go_refine(int unsigned r, bit up);
    step[r] = prev[r] / 2;
    if (up) trial[r] = clip9(trial[r] + step[r]);
    else trial[r] = trial[r] > step[r] ? trial[r] - step[r] : 0;
    ph[r] = (step[r] == 1) ? PH_FINAL : PH_REFINE;
  endfunction

  // one measurement into the region's search
  function automatic void measure(int unsigned r, logic [31:0] et, logic [47:0] mv);
    longint res;
    bit timed;
    timed = fallback[r] || reg_mode == 0 || reg_mode > 4;
    if (ph[r] == PH_DONE) return;
    if (timed) begin
      res = longint'({32'd0, et});
    end else begin
      res = longint'($signed(mv));
      if (res <= 0) begin
        ph[r] = PH_RESTART;
        fallback[r] = 1;
      end
    end
    case (ph[r])
      PH_RESTART: begin
        ph[r] = PH_FIRST;
        trial[r] = reg_start;
        prev[r] = reg_start;
      end
      PH_FIRST: begin
        best_m[r] = res;
        best[r] = trial[r];
        trial[r] = clip9(best[r] * 2);
        ph[r] = PH_DOUBLE;
      end
      PH_DOUBLE: begin
        if (res < best_m[r]) begin
          best_m[r] = res;
          best[r] = trial[r];
          if (!seq_done[r]) begin
            if (trial[r] * 2 <= reg_cores) begin
              prev[r] = trial[r];
              trial[r] = clip9(best[r] * 2);
            end else begin
              go_refine(r, 0);
            end
          end else begin
            ph[r] = PH_DONE;
          end
        end else if (trial[r] == reg_start * 2 && !seq_done[r]) begin
          prev[r] = trial[r];
          trial[r] = 1;
          seq_done[r] = 1;
        end else if (best[r] == reg_cores / 2) begin
          go_refine(r, 0);
        end else begin
          go_refine(r, 1);
        end
      end
      PH_REFINE: begin
        if (!(best_m[r] < res)) begin
          best[r] = trial[r];
          best_m[r] = res;
        end
        step[r] = step[r] / 2;
        trial[r] = clip9(trial[r] + step[r]);
        ph[r] = (step[r] == 1) ? PH_FINAL : PH_REFINE;
      end
      PH_FINAL: begin
        ph[r] = PH_DONE;
        if (res < best_m[r]) best[r] = trial[r];
      end
      default: ;
    endcase
  endfunction

  function automatic tuner_answer_t tune(logic op, logic [63:0] key, logic [31:0] et,
                                         logic [47:0] mv);
    tuner_answer_t a;
    int unsigned r;
    bit hit;
    a = '{default: '0};
    r = 0;
    hit = 0;
    if (op == 1'b0) begin
      for (int unsigned i = 0; i < key_count; i++) begin
        if (!hit && key_tab[i] == key) begin
          r = i;
          hit = 1;
        end
      end
      if (!hit) begin
        if (key_count >= MaxRegions) begin
          cur_ok = 0;
          a.threads = reg_start[8:0];
          a.full = 1;
          return a;
        end
        r = key_count;
        key_tab[r] = key;
        clear_slot(r);
        key_count++;
        a.fresh = 1;
      end
      cur_slot = r;
      cur_ok = 1;
    end else begin
      if (!cur_ok) return a;
      r = cur_slot;
      measure(r, et, mv);
    end
    if (ph[r] == PH_DONE) begin
      a.threads = best[r][8:0];
      a.done = 1;
    end else begin
      a.threads = trial[r][8:0];
    end
    a.slot = r[5:0];
    return a;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    tuner_answer_t w;
    if (!rst_n) begin
      reg_start = 1;
      reg_cores = 8;
      reg_mode = 0;
      key_count = 0;
      cur_slot = 0;
      cur_ok = 0;
      for (int r = 0; r < MaxRegions; r++) clear_slot(r);
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with no transaction waiting, actual %0d", $time,
                   out_thread_count);
          errors++;
        end else begin
          w = answer_q.pop_front();
          check_field("thread_count", w.threads, out_thread_count);
          check_field("region_index", w.slot, out_region_index);
          check_field("is_new_region", w.fresh, out_is_new_region);
          check_field("search_done", w.done, out_search_done);
          check_field("table_full", w.full, out_table_full);
        end
      end
      if (start && !busy)
        answer_q.push_back(tune(in_operation, in_region_key, in_elapsed_time,
                               in_metric_value));
      if (cfg_we) begin
        case (cfg_index)
          CfgStart: reg_start = cfg_data;
          CfgCores: reg_cores = cfg_data;
          CfgMode:  reg_mode = cfg_data[2:0];
          default: ;
        endcase
      end
    end
    pending = answer_q.size();
  end
endmodule

[bench/tb_thread_count_search_tuner_unit.sv]
`timescale 1ns / 1ps
module tb_thread_count_search_tuner_unit;
  import tcst_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam logic OpStart = 1'b0;
  localparam logic OpEnd   = 1'b1;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_operation = 0;
  logic [63:0] in_region_key = '0;
  logic [31:0] in_elapsed_time = '0;
  logic [47:0] in_metric_value = '0;
  logic        out_valid;
  logic [8:0]  out_thread_count;
  logic [5:0]  out_region_index;
  logic        out_is_new_region, out_search_done, out_table_full;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  int          errors, pending;
  int          cycles = 0;
  int          burst_left = 0;
  logic [63:0] keys[20];

  thread_count_search_tuner_unit dut (.*);
  tcst_result_checker u_checker (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hold the transaction until accepted; start stays high for the next one unless a burst ends, when it may drop first
  task automatic send(logic op, logic [63:0] key, logic [31:0] et, logic [47:0] mv);
    start <= 1'b1;
    in_operation <= op;
    in_region_key <= key;
    in_elapsed_time <= et;
    in_metric_value <= mv;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] pick_metric();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return '0;
    if (sel < 8) return -48'($urandom_range(1, 1000));
    if (sel < 14) return 48'({$urandom, $urandom});
    return 48'($urandom_range(1, 2000));
  endfunction

  function automatic logic [31:0] pick_time();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
  endfunction

  task automatic random_phase(int n_items, int n_keys, bit fresh_keys);
    int sent;
    sent = 0;
    if (fresh_keys)
      for (int i = 0; i < n_keys; i++) keys[i] = {$urandom, $urandom};
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send(OpStart, keys[$urandom_range(0, n_keys - 1)], $urandom,
             48'({$urandom, $urandom}));
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send(OpEnd, {$urandom, $urandom}, pick_time(), pick_metric());
          sent++;
        end
      end else begin
        send(logic'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
             48'({$urandom, $urandom}));
        sent++;
      end
    end
    drain();
  endtask

  task automatic settings(logic [8:0] st, logic [8:0] cores, logic [2:0] mode);
    write_reg(CfgStart, st);
    write_reg(CfgCores, cores);
    write_reg(CfgMode, {6'($urandom), mode});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end with no region, then default settings on extreme keys and times
    send(OpEnd, '0, 32'd10, 48'd10);
    send(OpStart, '0, '0, '0);
    repeat (6) send(OpEnd, '0, 32'($urandom_range(1, 500)), '0);
    send(OpStart, '0, '0, '0);
    send(OpStart, '1, '1, '1);
    send(OpEnd, '0, 32'hFFFF_FFFF, '0);
    send(OpEnd, '0, 32'd0, '0);
    send(OpEnd, '0, 32'd0, '0);
    drain();
    // metric mode with zero and negative metrics falling back to time
    write_reg(CfgMode, 9'd1);
    write_reg(2'd3, 9'h1FF);
    send(OpStart, 64'd1, '0, '0);
    send(OpEnd, '0, 32'd5, 48'h7FFF_FFFF_FFFF);
    send(OpEnd, '0, 32'd5, 48'h0000_0000_0000);
    send(OpEnd, '0, 32'd5, 48'h8000_0000_0000);
    send(OpEnd, '0, 32'd7, 48'h7FFF_FFFF_FFFF);
    send(OpStart, 64'd2, '0, '0);
    send(OpEnd, '0, 32'd5, 48'h7FFF_FFFF_FFFF);
    send(OpEnd, '0, 32'd5, 48'hFFFF_FFFF_FFFF);
    drain();

    settings(9'd256, 9'd256, 3'd1);
    random_phase(170, 7, 1);
    settings(9'd1, 9'd1, 3'd2);
    random_phase(170, 7, 1);
    settings(9'd2, 9'd16, 3'd3);
    random_phase(170, 7, 1);
    settings(9'd4, 9'd64, 3'd4);
    random_phase(170, 7, 1);
    settings(9'd3, 9'd12, 3'd7);
    random_phase(170, 7, 1);
    settings(9'd1, 9'd256, 3'd5);
    random_phase(170, 7, 1);
    // overflow the table with new keys
    settings(9'd256, 9'd1, 3'd0);
    random_phase(150, 20, 1);

    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/tcst_pkg.sv
rtl/tcst_key_scan.sv
rtl/tcst_search_step.sv
rtl/thread_count_search_tuner_unit.sv
bench/tcst_result_checker.sv
bench/tb_thread_count_search_tuner_unit.sv
